### rtl/epso_pkg.sv
// Shared types, constants and table-building functions for the pitch sine oscillator.
`timescale 1ns / 1ps
package epso_pkg;

  // Field and register widths
  localparam int CV_W       = 16;
  localparam int AUDIO_W    = 16;
  localparam int KNOB_W     = 13;
  localparam int C4_W       = 27;
  localparam int PHASE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SINE_VAL_W = 15;

  // Register reset values
  localparam logic [KNOB_W-1:0]  KNOB_RST       = 13'd0;
  localparam logic [C4_W-1:0]    C4_STEP_RST    = 27'd25481;
  localparam logic [PHASE_W-1:0] BLINK_STEP_RST = 32'd97391;

  // Right shift of the C4 step product is SHIFT_BASE minus the octave
  localparam logic [5:0]  SHIFT_BASE = 6'd34;
  localparam logic [30:0] STEP_MAX   = 31'h7FFF_FFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PITCH_KNOB = 2'd0,
    CFG_C4_STEP    = 2'd1,
    CFG_BLINK_STEP = 2'd2
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd_e0;
    logic rd_e1;
    logic interp;
    logic mul;
    logic step;
    logic phase;
    logic rd_sin;
    logic load_out;
  } epso_cmd_t;

  // Integer square root, bit-pair method
  function automatic logic [63:0] isqrt_f(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res   = 64'd0;
    bit_v = 64'h1 << 62;
    rem   = v;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 64'd0) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // One exp2 entry, Q2.30: 2^(i / 2^eb), built from repeated roots of two
  function automatic logic [31:0] exp_entry_f(input int unsigned eb, input int unsigned i);
    logic [63:0] roots [0:12];
    logic [63:0] e;
    if (i == (32'd1 << eb)) return 32'h8000_0000;
    roots[0] = 64'h1 << 31;
    for (int k = 1; k <= 12; k++) begin
      if (k <= eb) roots[k] = isqrt_f(roots[k-1] << 30);
      else roots[k] = 64'd0;
    end
    e = 64'h1 << 30;
    for (int b = 0; b < 12; b++) begin
      if (b < eb && i[b]) e = (e * roots[eb-b] + (64'h1 << 29)) >> 30;
    end
    return e[31:0];
  endfunction

  // One quarter-wave entry: round(20480 * sin(pi/2 * i / 2^sb)), Taylor series in Q2.30
  function automatic logic [SINE_VAL_W-1:0] sine_entry_f(input int unsigned sb,
                                                          input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        s;
    x    = (64'd1686629713 * 64'(i)) >> sb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
    if (sum < 64'sd0) sum = 64'sd0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    s = unsigned'(sum);
    return SINE_VAL_W'((s * 64'd20480 + (64'h1 << 29)) >> 30);
  endfunction

endpackage

### rtl/epso_ctrl.sv
// Sequencing state machine: handshakes and per-step datapath commands.
`timescale 1ns / 1ps
module epso_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output epso_pkg::epso_cmd_t cmd
);
  import epso_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXP0, ST_EXP1, ST_INTERP, ST_MUL, ST_STEP, ST_PHASE, ST_ROM, ST_FIN
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && in_ready_r;
    cmd.rd_e0    = (state_r == ST_EXP0);
    cmd.rd_e1    = (state_r == ST_EXP1);
    cmd.interp   = (state_r == ST_INTERP);
    cmd.mul      = (state_r == ST_MUL);
    cmd.step     = (state_r == ST_STEP);
    cmd.phase    = (state_r == ST_PHASE);
    cmd.rd_sin   = (state_r == ST_ROM);
    cmd.load_out = (state_r == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // A load in the same cycle keeps valid high; it is set in ST_FIN below
      if (out_valid_r && out_ready && !cmd.load_out) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            in_ready_r <= 1'b0;
            state_r    <= ST_EXP0;
          end
        end
        ST_EXP0:   state_r <= ST_EXP1;
        ST_EXP1:   state_r <= ST_INTERP;
        ST_INTERP: state_r <= ST_MUL;
        ST_MUL:    state_r <= ST_STEP;
        ST_STEP:   state_r <= ST_PHASE;
        ST_PHASE:  state_r <= ST_ROM;
        ST_ROM:    state_r <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            in_ready_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/epso_dp.sv
// Datapath: config registers, exp2 pitch-to-step, phase accumulators, sine lookup.
`timescale 1ns / 1ps
module epso_dp #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int EXP_TABLE_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  epso_pkg::epso_cmd_t                   cmd,
  input  logic signed [epso_pkg::CV_W-1:0]      in_pitch_cv,
  input  logic                                  cfg_we,
  input  logic [epso_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [epso_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic signed [epso_pkg::AUDIO_W-1:0]   out_audio_out,
  output logic                                  out_light_on
);
  import epso_pkg::*;

  localparam int EXP_N = 1 << EXP_TABLE_BITS;
  localparam int SINE_N = 1 << SINE_TABLE_BITS;
  localparam int EA_W = EXP_TABLE_BITS + 1;
  localparam int SA_W = SINE_TABLE_BITS + 1;
  localparam int RB = 12 - EXP_TABLE_BITS;
  localparam int RW = (RB == 0) ? 1 : RB;
  localparam logic [11:0] RMASK = 12'((1 << RB) - 1);

  typedef logic [31:0] exp_tab_t [EXP_N+1];
  typedef logic [SINE_VAL_W-1:0] sine_tab_t [SINE_N+1];

  function automatic exp_tab_t exp_tab_build_f();
    exp_tab_t t;
    for (int i = 0; i <= EXP_N; i++) t[i] = exp_entry_f(EXP_TABLE_BITS, i);
    return t;
  endfunction

  function automatic sine_tab_t sine_tab_build_f();
    sine_tab_t t;
    for (int i = 0; i <= SINE_N; i++) t[i] = sine_entry_f(SINE_TABLE_BITS, i);
    return t;
  endfunction

  localparam exp_tab_t  EXP_TAB  = exp_tab_build_f();
  localparam sine_tab_t SINE_TAB = sine_tab_build_f();

  // Config and oscillator state
  logic [KNOB_W-1:0]  knob_r;
  logic [C4_W-1:0]    c4_r;
  logic [PHASE_W-1:0] blink_step_r;
  logic [PHASE_W-1:0] osc_r;
  logic [PHASE_W-1:0] blink_r;

  // Per-item working registers
  logic [3:0]                oct_r;
  logic [EXP_TABLE_BITS-1:0] j_r;
  logic [RW-1:0]             r_r;
  logic [31:0]               e0_r;
  logic [31:0]               e1_r;
  logic [31:0]               m_r;
  logic [58:0]               prod_r;
  logic [30:0]               step_r;
  logic [SA_W-1:0]           addr_r;
  logic                      neg_r;
  logic                      light_r;
  logic [SINE_VAL_W-1:0]     sin_r;
  logic [AUDIO_W-1:0]        audio_r;
  logic                      light_out_r;

  // Pitch clamp and split into octave / table index / remainder
  logic signed [17:0] pitch_sum;
  logic signed [17:0] pitch_clamp;
  logic [15:0]        q;
  logic [11:0]        f;

  assign pitch_sum = $signed({5'b0, knob_r}) + $signed({{2{in_pitch_cv[CV_W-1]}}, in_pitch_cv});

  always_comb begin
    if (pitch_sum < -18'sd16384) pitch_clamp = -18'sd16384;
    else if (pitch_sum > 18'sd16384) pitch_clamp = 18'sd16384;
    else pitch_clamp = pitch_sum;
  end

  assign q = 16'(pitch_clamp + 18'sd16384);
  assign f = q[11:0];

  // Exp table read port, one entry per cycle
  logic [EA_W-1:0] e_addr;
  logic [31:0]     e_q;
  assign e_addr = cmd.rd_e1 ? ({1'b0, j_r} + EA_W'(1)) : {1'b0, j_r};
  assign e_q    = EXP_TAB[e_addr];

  // Linear interpolation between adjacent entries
  logic [31:0]      e_diff;
  logic [31+RW:0]   ip;
  logic [31:0]      m_nxt;
  assign e_diff = e1_r - e0_r;
  assign ip     = (32+RW)'(e_diff) * (32+RW)'(r_r);
  assign m_nxt  = e0_r + 32'(ip >> RB);

  // Rounded octave shift with saturation
  logic [5:0]  shamt;
  logic [59:0] rnd;
  logic [59:0] shifted;
  logic [30:0] step_nxt;
  assign shamt    = SHIFT_BASE - {2'b0, oct_r};
  assign rnd      = {1'b0, prod_r} + (60'd1 << (shamt - 6'd1));
  assign shifted  = rnd >> shamt;
  assign step_nxt = (shifted > {29'd0, STEP_MAX}) ? STEP_MAX : shifted[30:0];

  // Phase advance and quarter-wave address
  logic [PHASE_W-1:0]         osc_nxt;
  logic [PHASE_W-1:0]         blink_nxt;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SA_W-1:0]            addr_nxt;
  assign osc_nxt   = osc_r + {1'b0, step_r};
  assign blink_nxt = blink_r + blink_step_r;
  assign idx       = osc_nxt[29 -: SINE_TABLE_BITS];
  assign addr_nxt  = osc_nxt[30] ? (SA_W'(SINE_N) - {1'b0, idx}) : {1'b0, idx};

  logic [AUDIO_W-1:0] audio_nxt;
  assign audio_nxt = neg_r ? (-{1'b0, sin_r}) : {1'b0, sin_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knob_r       <= KNOB_RST;
      c4_r         <= C4_STEP_RST;
      blink_step_r <= BLINK_STEP_RST;
      osc_r        <= '0;
      blink_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PITCH_KNOB: knob_r       <= cfg_wdata[KNOB_W-1:0];
          CFG_C4_STEP:    c4_r         <= cfg_wdata[C4_W-1:0];
          CFG_BLINK_STEP: blink_step_r <= cfg_wdata[PHASE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.phase) begin
        osc_r   <= osc_nxt;
        blink_r <= blink_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      oct_r <= q[15:12];
      j_r   <= EXP_TABLE_BITS'(f >> RB);
      r_r   <= RW'(f & RMASK);
    end
    if (cmd.rd_e0)  e0_r   <= e_q;
    if (cmd.rd_e1)  e1_r   <= e_q;
    if (cmd.interp) m_r    <= m_nxt;
    if (cmd.mul)    prod_r <= {32'd0, c4_r} * {27'd0, m_r};
    if (cmd.step)   step_r <= step_nxt;
    if (cmd.phase) begin
      addr_r  <= addr_nxt;
      neg_r   <= osc_nxt[31];
      light_r <= ~blink_nxt[31];
    end
    if (cmd.rd_sin) sin_r <= SINE_TAB[addr_r];
    if (cmd.load_out) begin
      audio_r     <= audio_nxt;
      light_out_r <= light_r;
    end
  end

  assign out_audio_out = $signed(audio_r);
  assign out_light_on  = light_out_r;

endmodule

### rtl/exp_pitch_sine_oscillator.sv
// Top level: volt-per-octave sine oscillator with a 1 Hz blink light.
`timescale 1ns / 1ps
//
//  Channel  Ports                                   Flow
//  -------  --------------------------------------  ---------------------------
//  input    in_valid, in_ready, in_pitch_cv         one item per sample tick
//  result   out_valid, out_ready, out_audio_out,    one item per input item
//           out_light_on
//  config   cfg_we, cfg_index, cfg_wdata            write only, no wait
//
//  From acceptance to the next acceptance an item takes one pass of the
//  controller through two exp table reads, the interpolation, the
//  27x32 step multiply, the octave shift, the phase add and the sine ROM read.
//  The finished item sits in the output register; a new item is accepted
//  while it waits, and only the final load stalls if it has not been taken.
//  Synchronous active-low reset clears both phase accumulators and loads the
//  config registers with their defaults; the tables are constants, no fill.
//
//  Pitch: knob + cv, clamped to +-4 V, split into an octave (shift) and a
//  fraction (exp2 table with linear interpolation). The step scales the C4
//  step, saturates at half a cycle per sample, and drives a 32-bit wrapping
//  phase. Output is 5 V * sin from a quarter-wave table, mirrored and negated.
module exp_pitch_sine_oscillator #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int EXP_TABLE_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [epso_pkg::CV_W-1:0]    in_pitch_cv,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [epso_pkg::AUDIO_W-1:0] out_audio_out,
  output logic                                out_light_on,
  input  logic                                cfg_we,
  input  logic [epso_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [epso_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import epso_pkg::*;

  epso_cmd_t cmd;

  epso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  epso_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .EXP_TABLE_BITS  (EXP_TABLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_pitch_cv   (in_pitch_cv),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_audio_out (out_audio_out),
    .out_light_on  (out_light_on)
  );

  // One item at a time: acceptance closes the input until the result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after an item was accepted");

  // Accepted item starts with the first exp table read
  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##1 cmd.rd_e0)
    else $error("accepted item did not start the exp table read");

  // Result register never overwritten while an untaken result sits there
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register loaded over an untaken item");

  // Output amplitude stays within 5 V
  a_audio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_audio_out <= 16'sd20480) && (out_audio_out >= -16'sd20480)))
    else $error("audio output beyond 5 V");

endmodule
